// File: hdl/trs_pkg.sv
// Shared types, state codes and status codes of the topic router.
package trs_pkg;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int SUM_W = 64;
    localparam int CNT_W = 32;
    localparam int SLOT_W = 6;
    localparam int DCNT_W = 7;
    localparam int STATUS_W = 3;

    localparam logic [1:0] OP_PUBLISH = 2'd0;
    localparam logic [1:0] OP_SUBSCRIBE = 2'd1;
    localparam logic [1:0] OP_UNSUBSCRIBE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DELIVERY = 3'd0;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 3'd1;
    localparam logic [STATUS_W-1:0] ST_SUBSCRIBED = 3'd2;
    localparam logic [STATUS_W-1:0] ST_SUB_FULL = 3'd3;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NO_EFFECT = 3'd5;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic signed [SUM_W-1:0] sum;
        logic signed [VAL_W-1:0] min;
        logic signed [VAL_W-1:0] max;
    } trs_stats_t;

    typedef struct packed {
        logic [KEY_W-1:0] id;
        trs_stats_t stats;
    } trs_entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TRD,
        S_TCHK,
        S_TUPD,
        S_TNEW,
        S_SRD,
        S_SCHK,
        S_FLUSH,
        S_SUB,
        S_UNSUB,
        S_BAD
    } trs_state_t;

endpackage

// File: hdl/trs_stat_update.sv
// Saturating update of one topic's count, sum, minimum and maximum.
module trs_stat_update
(
    input  trs_pkg::trs_stats_t old_stats,
    input  logic signed [trs_pkg::VAL_W-1:0] value,
    output trs_pkg::trs_stats_t new_stats
);

    logic signed [trs_pkg::SUM_W:0] wide_sum;

    assign wide_sum = {old_stats.sum[trs_pkg::SUM_W-1], old_stats.sum}
        + (trs_pkg::SUM_W+1)'(value);

    always_comb
    begin
        new_stats.count = (old_stats.count == '1) ? old_stats.count
                                                   : old_stats.count + 1'b1;
        if (wide_sum[trs_pkg::SUM_W] != wide_sum[trs_pkg::SUM_W-1])
        begin
            new_stats.sum = wide_sum[trs_pkg::SUM_W]
                ? {1'b1, {(trs_pkg::SUM_W-1){1'b0}}}
                : {1'b0, {(trs_pkg::SUM_W-1){1'b1}}};
        end
        else
        begin
            new_stats.sum = wide_sum[trs_pkg::SUM_W-1:0];
        end
        new_stats.min = (value < old_stats.min) ? value : old_stats.min;
        new_stats.max = (value > old_stats.max) ? value : old_stats.max;
    end

endmodule

// File: hdl/trs_topic_mem.sv
// Topic table memory holding key and statistics, with a registered read.
module trs_topic_mem
#(
    parameter int DEPTH = 32,
    parameter int AW = 5
)
(
    input  logic clk,
    input  logic we,
    input  logic [AW-1:0] waddr,
    input  trs_pkg::trs_entry_t wdata,
    input  logic [AW-1:0] raddr,
    output trs_pkg::trs_entry_t rdata
);

    trs_pkg::trs_entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/trs_filter_mem.sv
// Subscriber filter memory with a registered read.
module trs_filter_mem
#(
    parameter int DEPTH = 64,
    parameter int AW = 6
)
(
    input  logic clk,
    input  logic we,
    input  logic [AW-1:0] waddr,
    input  logic [trs_pkg::KEY_W-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [trs_pkg::KEY_W-1:0] rdata
);

    logic [trs_pkg::KEY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/topic_router_with_stats.sv
// Top level of the topic router: sequencer, subscriber state and result register.
//
// One request is taken at a time. A publish first walks the filled part of
// the topic table until it finds the key, with a read state and a check state
// per entry (the memory read is registered), then updates the statistics or
// adds a new entry if there is room, then walks all SUB_SLOTS subscriber slots
// with a read and a check state per slot and ends with a flush state.
// Deliveries leave in slot order as they are found; each one is held until the
// next match or the end of the walk so the last one carries last. Topic entries
// are never freed, so a fill count marks the used entries and no clearing pass
// is needed after reset.
module topic_router_with_stats
#(
    parameter int TOPIC_SLOTS = 32,
    parameter int SUB_SLOTS = 64
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  logic [1:0] op,
    input  logic [trs_pkg::KEY_W-1:0] topic_key,
    input  logic signed [trs_pkg::VAL_W-1:0] sample_value,
    input  logic [trs_pkg::SLOT_W-1:0] sub_slot,
    output logic rsp_valid,
    input  logic rsp_stall,
    output logic [trs_pkg::STATUS_W-1:0] status,
    output logic [trs_pkg::SLOT_W-1:0] slot,
    output logic last,
    output logic [trs_pkg::DCNT_W-1:0] delivered_count,
    output logic topic_untracked,
    output logic [trs_pkg::CNT_W-1:0] topic_messages,
    output logic signed [trs_pkg::SUM_W-1:0] topic_sum,
    output logic signed [trs_pkg::VAL_W-1:0] topic_min,
    output logic signed [trs_pkg::VAL_W-1:0] topic_max
);

    localparam int TW = (TOPIC_SLOTS > 1) ? $clog2(TOPIC_SLOTS) : 1;
    localparam int FW = $clog2(TOPIC_SLOTS + 1);
    localparam int SW = (SUB_SLOTS > 1) ? $clog2(SUB_SLOTS) : 1;

    trs_pkg::trs_state_t state_reg, state_next;

    logic [1:0] op_reg, op_next;
    logic [trs_pkg::KEY_W-1:0] key_reg, key_next;
    logic signed [trs_pkg::VAL_W-1:0] val_reg, val_next;
    logic [trs_pkg::SLOT_W-1:0] sslot_reg, sslot_next;
    logic [TW-1:0] tidx_reg, tidx_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [SW-1:0] sidx_reg, sidx_next;
    logic [SUB_SLOTS-1:0] used_reg, used_next;
    logic pend_reg, pend_next;
    logic [SW-1:0] pslot_reg, pslot_next;
    logic [trs_pkg::DCNT_W-1:0] n_reg, n_next;
    logic untr_reg, untr_next;
    trs_pkg::trs_stats_t stats_reg, stats_next;
    logic [31:0] tot_pub_reg, tot_pub_next;
    logic [31:0] tot_del_reg, tot_del_next;

    logic rsp_valid_reg;
    logic [trs_pkg::STATUS_W-1:0] status_reg;
    logic [trs_pkg::SLOT_W-1:0] slot_reg;
    logic last_reg;
    logic [trs_pkg::DCNT_W-1:0] dcnt_reg;
    logic untracked_reg;
    trs_pkg::trs_stats_t ostats_reg;

    logic emit;
    logic [trs_pkg::STATUS_W-1:0] e_status;
    logic [trs_pkg::SLOT_W-1:0] e_slot;
    logic e_last;
    logic [trs_pkg::DCNT_W-1:0] e_dcnt;
    logic e_pub;

    logic out_free;
    logic topic_we;
    logic [TW-1:0] topic_waddr;
    trs_pkg::trs_entry_t topic_wdata, topic_rdata;
    trs_pkg::trs_stats_t upd_stats;
    logic filt_we;
    logic [trs_pkg::KEY_W-1:0] filt_rdata;
    logic free_any;
    logic [SW-1:0] free_idx;
    logic hit;
    logic t_last;
    logic s_last;
    logic sslot_ok;
    logic advance;

    trs_topic_mem #(.DEPTH(TOPIC_SLOTS), .AW(TW)) u_topic_mem
    (
        .clk(clk),
        .we(topic_we),
        .waddr(topic_waddr),
        .wdata(topic_wdata),
        .raddr(tidx_reg),
        .rdata(topic_rdata)
    );

    trs_filter_mem #(.DEPTH(SUB_SLOTS), .AW(SW)) u_filter_mem
    (
        .clk(clk),
        .we(filt_we),
        .waddr(free_idx),
        .wdata(key_reg),
        .raddr(sidx_reg),
        .rdata(filt_rdata)
    );

    trs_stat_update u_stat_update
    (
        .old_stats(topic_rdata.stats),
        .value(val_reg),
        .new_stats(upd_stats)
    );

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SUB_SLOTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign hit = used_reg[sidx_reg] && (filt_rdata == key_reg);
    assign t_last = ((FW'(tidx_reg) + 1'b1) == fill_reg);
    assign s_last = (sidx_reg == SW'(SUB_SLOTS - 1));
    assign sslot_ok = ({1'b0, sslot_reg} < 7'(SUB_SLOTS));
    assign advance = !(hit && pend_reg && !out_free);
    assign req_stall = (state_reg != trs_pkg::S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            trs_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (op == trs_pkg::OP_PUBLISH)
                    begin
                        state_next = (fill_reg == '0) ? trs_pkg::S_TNEW : trs_pkg::S_TRD;
                    end
                    else if (op == trs_pkg::OP_SUBSCRIBE)
                    begin
                        state_next = trs_pkg::S_SUB;
                    end
                    else if (op == trs_pkg::OP_UNSUBSCRIBE)
                    begin
                        state_next = trs_pkg::S_UNSUB;
                    end
                    else
                    begin
                        state_next = trs_pkg::S_BAD;
                    end
                end
            end
            trs_pkg::S_TRD:
            begin
                state_next = trs_pkg::S_TCHK;
            end
            trs_pkg::S_TCHK:
            begin
                if (topic_rdata.id == key_reg)
                begin
                    state_next = trs_pkg::S_TUPD;
                end
                else if (t_last)
                begin
                    state_next = trs_pkg::S_TNEW;
                end
                else
                begin
                    state_next = trs_pkg::S_TRD;
                end
            end
            trs_pkg::S_TUPD, trs_pkg::S_TNEW:
            begin
                state_next = trs_pkg::S_SRD;
            end
            trs_pkg::S_SRD:
            begin
                state_next = trs_pkg::S_SCHK;
            end
            trs_pkg::S_SCHK:
            begin
                if (advance)
                begin
                    state_next = s_last ? trs_pkg::S_FLUSH : trs_pkg::S_SRD;
                end
            end
            trs_pkg::S_FLUSH, trs_pkg::S_SUB, trs_pkg::S_UNSUB, trs_pkg::S_BAD:
            begin
                if (out_free)
                begin
                    state_next = trs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = trs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next = op_reg;
        key_next = key_reg;
        val_next = val_reg;
        sslot_next = sslot_reg;
        tidx_next = tidx_reg;
        fill_next = fill_reg;
        sidx_next = sidx_reg;
        used_next = used_reg;
        pend_next = pend_reg;
        pslot_next = pslot_reg;
        n_next = n_reg;
        untr_next = untr_reg;
        stats_next = stats_reg;
        tot_pub_next = tot_pub_reg;
        tot_del_next = tot_del_reg;
        emit = 1'b0;
        e_status = trs_pkg::ST_NO_EFFECT;
        e_slot = '0;
        e_last = 1'b1;
        e_dcnt = '0;
        e_pub = 1'b0;
        topic_we = 1'b0;
        topic_waddr = tidx_reg;
        topic_wdata = {key_reg, upd_stats};
        filt_we = 1'b0;
        unique case (state_reg)
            trs_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next = op;
                    key_next = topic_key;
                    val_next = sample_value;
                    sslot_next = sub_slot;
                    tidx_next = '0;
                    sidx_next = '0;
                    pend_next = 1'b0;
                    n_next = '0;
                    untr_next = 1'b0;
                    if (op == trs_pkg::OP_PUBLISH)
                    begin
                        tot_pub_next = tot_pub_reg + 1'b1;
                    end
                end
            end
            trs_pkg::S_TRD:
            begin
            end
            trs_pkg::S_TCHK:
            begin
                if (topic_rdata.id != key_reg && !t_last)
                begin
                    tidx_next = tidx_reg + 1'b1;
                end
            end
            trs_pkg::S_TUPD:
            begin
                topic_we = 1'b1;
                stats_next = upd_stats;
            end
            trs_pkg::S_TNEW:
            begin
                if (fill_reg < FW'(TOPIC_SLOTS))
                begin
                    topic_we = 1'b1;
                    topic_waddr = fill_reg[TW-1:0];
                    topic_wdata = {key_reg, 32'd1, 64'(val_reg), val_reg, val_reg};
                    stats_next = {32'd1, 64'(val_reg), val_reg, val_reg};
                    fill_next = fill_reg + 1'b1;
                end
                else
                begin
                    untr_next = 1'b1;
                    stats_next = '0;
                end
            end
            trs_pkg::S_SRD:
            begin
            end
            trs_pkg::S_SCHK:
            begin
                if (hit && advance)
                begin
                    if (pend_reg)
                    begin
                        emit = 1'b1;
                        e_pub = 1'b1;
                        e_status = trs_pkg::ST_DELIVERY;
                        e_slot = trs_pkg::SLOT_W'(pslot_reg);
                        e_last = 1'b0;
                        e_dcnt = n_reg;
                    end
                    pend_next = 1'b1;
                    pslot_next = sidx_reg;
                    n_next = n_reg + 1'b1;
                end
                if (advance && !s_last)
                begin
                    sidx_next = sidx_reg + 1'b1;
                end
            end
            trs_pkg::S_FLUSH:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    e_pub = 1'b1;
                    e_status = pend_reg ? trs_pkg::ST_DELIVERY : trs_pkg::ST_NO_MATCH;
                    e_slot = pend_reg ? trs_pkg::SLOT_W'(pslot_reg) : '0;
                    e_dcnt = n_reg;
                    tot_del_next = tot_del_reg + 32'(n_reg);
                    pend_next = 1'b0;
                end
            end
            trs_pkg::S_SUB:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    if (free_any)
                    begin
                        filt_we = 1'b1;
                        used_next[free_idx] = 1'b1;
                        e_status = trs_pkg::ST_SUBSCRIBED;
                        e_slot = trs_pkg::SLOT_W'(free_idx);
                    end
                    else
                    begin
                        e_status = trs_pkg::ST_SUB_FULL;
                    end
                end
            end
            trs_pkg::S_UNSUB:
            begin
                if (out_free)
                begin
                    emit = 1'b1;
                    e_slot = sslot_reg;
                    if (sslot_ok && used_reg[sslot_reg[SW-1:0]])
                    begin
                        used_next[sslot_reg[SW-1:0]] = 1'b0;
                        e_status = trs_pkg::ST_REMOVED;
                    end
                end
            end
            trs_pkg::S_BAD:
            begin
                emit = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trs_pkg::S_IDLE;
            fill_reg <= '0;
            used_reg <= '0;
            pend_reg <= 1'b0;
            n_reg <= '0;
            tot_pub_reg <= '0;
            tot_del_reg <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            used_reg <= used_next;
            pend_reg <= pend_next;
            n_reg <= n_next;
            tot_pub_reg <= tot_pub_next;
            tot_del_reg <= tot_del_next;
            if (emit)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next;
        key_reg <= key_next;
        val_reg <= val_next;
        sslot_reg <= sslot_next;
        tidx_reg <= tidx_next;
        sidx_reg <= sidx_next;
        pslot_reg <= pslot_next;
        untr_reg <= untr_next;
        stats_reg <= stats_next;
        if (emit)
        begin
            status_reg <= e_status;
            slot_reg <= e_slot;
            last_reg <= e_last;
            dcnt_reg <= e_dcnt;
            untracked_reg <= e_pub && untr_reg;
            ostats_reg <= e_pub ? stats_reg : '0;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign status = status_reg;
    assign slot = slot_reg;
    assign last = last_reg;
    assign delivered_count = dcnt_reg;
    assign topic_untracked = untracked_reg;
    assign topic_messages = ostats_reg.count;
    assign topic_sum = ostats_reg.sum;
    assign topic_min = ostats_reg.min;
    assign topic_max = ostats_reg.max;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FW'(TOPIC_SLOTS))
        else $error("Topic fill count exceeds the table size.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == trs_pkg::S_IDLE) |-> !pend_reg)
        else $error("A delivery is still held while idle.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == trs_pkg::ST_DELIVERY) |-> (delivered_count != '0))
        else $error("A delivery carries a zero delivery count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !last) |-> (status == trs_pkg::ST_DELIVERY))
        else $error("Only deliveries may be followed by further results.");
`endif

endmodule
